// ===== design/u8d_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
package u8d_pkg;

  localparam logic [20:0] REPL_CHAR    = 21'h00FFFD;
  localparam logic [20:0] SURR_LO      = 21'h00D800;
  localparam logic [20:0] SURR_HI      = 21'h00DFFF;
  localparam logic [20:0] MIN_2BYTE    = 21'h000080;
  localparam logic [20:0] MIN_3BYTE    = 21'h000800;
  localparam logic [20:0] MIN_4BYTE    = 21'h010000;

  localparam logic [1:0] SEQ_NONE = 2'd0;
  localparam logic [1:0] SEQ_TWO  = 2'd1;
  localparam logic [1:0] SEQ_THREE = 2'd2;
  localparam logic [1:0] SEQ_FOUR = 2'd3;

  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_kind_t;

  // one decoded result before the last flag is attached
  typedef struct packed {
    logic [20:0] code_point;
    logic        replaced;
  } res_t;

  // everything one byte produces
  typedef struct packed {
    logic [1:0] n_res;
    res_t       r0;
    res_t       r1;
  } step_t;

  // one word on the result channel
  typedef struct packed {
    logic [20:0] code_point;
    logic        replaced;
    logic        last;
  } cp_word_t;

  function automatic lead_kind_t lead_kind(input logic [7:0] b);
    lead_kind_t k;
    if (b[7] == 1'b0) k = LEAD_ASCII;
    else if (b[7:5] == 3'b110) k = LEAD_TWO;
    else if (b[7:4] == 4'b1110) k = LEAD_THREE;
    else if (b[7:3] == 5'b11110) k = LEAD_FOUR;
    else k = LEAD_BAD;
    return k;
  endfunction

endpackage

// ===== design/u8d_stream_if.sv =====
// Handshake channels for raw bytes in and decoded code points out.
interface u8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface u8d_cp_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        replaced;
  logic        last;
  modport source (output valid, output code_point, output replaced, output last, input ready);
  modport sink (input valid, input code_point, input replaced, input last, output ready);
endinterface

// ===== design/u8d_decode.sv =====
// Sequence state and combinational decode of one byte into zero to two results.
module u8d_decode (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     byte_in,
  output u8d_pkg::step_t step
);
  import u8d_pkg::*;

  logic [1:0]  pending_count, pending_count_next;
  logic [1:0]  sequence_length, sequence_length_next;
  logic [20:0] partial_value, partial_value_next;

  logic        is_cont;
  logic [20:0] shifted;
  logic        bad_value;
  lead_kind_t  kind;
  res_t        lead_res;
  logic        lead_emits;

  assign is_cont = (byte_in[7:6] == 2'b10);
  assign shifted = {partial_value[14:0], byte_in[5:0]};
  assign kind    = lead_kind(byte_in);

  always_comb begin
    bad_value = (shifted >= SURR_LO) && (shifted <= SURR_HI);
    case (sequence_length)
      SEQ_TWO:   bad_value = bad_value || (shifted < MIN_2BYTE);
      SEQ_THREE: bad_value = bad_value || (shifted < MIN_3BYTE);
      SEQ_FOUR:  bad_value = bad_value || (shifted < MIN_4BYTE);
      default:   ;
    endcase
  end

  always_comb begin
    lead_res   = '{code_point: REPL_CHAR, replaced: 1'b1};
    lead_emits = 1'b1;
    unique case (kind) inside
      LEAD_ASCII: lead_res = '{code_point: {13'd0, byte_in}, replaced: 1'b0};
      LEAD_TWO, LEAD_THREE, LEAD_FOUR: lead_emits = 1'b0;
      default: ;
    endcase
  end

  always_comb begin
    step                 = '0;
    pending_count_next   = pending_count;
    sequence_length_next = sequence_length;
    partial_value_next   = partial_value;
    if (pending_count != SEQ_NONE && is_cont) begin
      pending_count_next = pending_count - 2'd1;
      partial_value_next = shifted;
      if (pending_count == 2'd1) begin
        step.n_res           = 2'd1;
        step.r0.code_point   = bad_value ? REPL_CHAR : shifted;
        step.r0.replaced     = bad_value;
        sequence_length_next = SEQ_NONE;
        partial_value_next   = '0;
      end
    end else begin
      // an interrupted sequence gives a replacement ahead of the lead's own result
      if (pending_count != SEQ_NONE) begin
        step.r0    = '{code_point: REPL_CHAR, replaced: 1'b1};
        step.r1    = lead_res;
        step.n_res = lead_emits ? 2'd2 : 2'd1;
      end else begin
        step.r0    = lead_res;
        step.n_res = lead_emits ? 2'd1 : 2'd0;
      end
      pending_count_next   = SEQ_NONE;
      sequence_length_next = SEQ_NONE;
      partial_value_next   = '0;
      unique case (kind)
        LEAD_TWO: begin
          pending_count_next   = SEQ_TWO;
          sequence_length_next = SEQ_TWO;
          partial_value_next   = {16'd0, byte_in[4:0]};
        end
        LEAD_THREE: begin
          pending_count_next   = SEQ_THREE;
          sequence_length_next = SEQ_THREE;
          partial_value_next   = {17'd0, byte_in[3:0]};
        end
        LEAD_FOUR: begin
          pending_count_next   = SEQ_FOUR;
          sequence_length_next = SEQ_FOUR;
          partial_value_next   = {18'd0, byte_in[2:0]};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count   <= SEQ_NONE;
      sequence_length <= SEQ_NONE;
      partial_value   <= '0;
    end else if (accept) begin
      pending_count   <= pending_count_next;
      sequence_length <= sequence_length_next;
      partial_value   <= partial_value_next;
    end
  end

  a_pending_le_len: assert property (@(posedge clk) disable iff (rst)
    pending_count <= sequence_length)
    else $error("pending count exceeds sequence length");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (pending_count == SEQ_NONE) |-> (sequence_length == SEQ_NONE))
    else $error("sequence length left over with no sequence open");

  a_two_first_repl: assert property (@(posedge clk) disable iff (rst)
    (step.n_res == 2'd2) |-> (step.r0.replaced && pending_count != SEQ_NONE))
    else $error("two results without an interrupted sequence");

  a_cont_done: assert property (@(posedge clk) disable iff (rst)
    (accept && is_cont && pending_count == 2'd1) |=> (pending_count == SEQ_NONE))
    else $error("sequence did not close on its last continuation");

endmodule

// ===== design/u8d_out_queue.sv =====
// Four-word result queue taking up to two words a cycle and giving one while out_ready is high.
module u8d_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u8d_pkg::step_t    step,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output u8d_pkg::cp_word_t out_word
);
  import u8d_pkg::*;

  cp_word_t   mem [4];
  logic [1:0] wptr, rptr;
  logic [2:0] count, count_next;
  logic [1:0] n_push;
  logic       pop;
  cp_word_t   w0, w1;

  assign n_push    = push ? step.n_res : 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 3'd0);
  assign room      = (count <= 3'd2);
  assign out_word  = mem[rptr];

  assign w0 = '{code_point: step.r0.code_point, replaced: step.r0.replaced,
                last: (step.n_res == 2'd1)};
  assign w1 = '{code_point: step.r1.code_point, replaced: step.r1.replaced, last: 1'b1};

  assign count_next = count + {1'b0, n_push} - {2'd0, pop};

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) mem[wptr] <= w0;
    if (n_push == 2'd2) mem[wptr + 2'd1] <= w1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + n_push;
      rptr  <= rptr + {1'b0, pop};
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (n_push != 2'd0) |-> room)
    else $error("push without room");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && n_push == 2'd0) |=> (count == $past(count) - 3'd1))
    else $error("queue count wrong after a pop");

endmodule

// ===== design/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder.
// Takes one byte word per cycle while the queue has room and gives decoded code point
// words. The byte is decoded in the cycle it is accepted against the open-sequence
// state, and its zero, one or two results enter a four-word result queue; a byte is
// taken whenever the queue holds two words or fewer, independent of the result side.
// The result side gives one word per cycle while the receiver is ready; input runs
// at one byte per cycle until the queue fills, from bytes that each give two results
// or a stalled result side. A byte's results are registered in the queue, in order.
module utf8_stream_decoder (
  input logic    clk,
  input logic    rst,
  u8d_byte_if.sink byte_stream,
  u8d_cp_if.source cp_stream
);
  import u8d_pkg::*;

  step_t    step;
  logic     room;
  logic     accept;
  cp_word_t out_word;

  assign byte_stream.ready = room;
  assign accept = byte_stream.valid && room;

  u8d_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .byte_in (byte_stream.byte_in),
    .step    (step)
  );

  u8d_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .step      (step),
    .room      (room),
    .out_valid (cp_stream.valid),
    .out_ready (cp_stream.ready),
    .out_word  (out_word)
  );

  assign cp_stream.code_point = out_word.code_point;
  assign cp_stream.replaced   = out_word.replaced;
  assign cp_stream.last       = out_word.last;

endmodule

// ===== test/utf8_stream_decoder_checker.sv =====
// Watches both channels of the UTF-8 decoder, predicts each code point word and compares.
module utf8_stream_decoder_checker (
  input  logic clk,
  input  logic rst,
  u8d_byte_if  byte_mon,
  u8d_cp_if    cp_mon,
  output int   fail_count,
  output int   outstanding
);
  import u8d_pkg::*;

  // decoder state as seen from outside
  logic [1:0]  conts_due;
  logic [1:0]  seq_kind;
  logic [20:0] cp_accum;

  cp_word_t expected_cps[$];

  function automatic void push_cp(input logic [20:0] cp, input logic bad);
    cp_word_t w;
    w.code_point = cp;
    w.replaced   = bad;
    w.last       = 1'b0;
    expected_cps.push_back(w);
  endfunction

  function automatic void open_sequence(input logic [7:0] b);
    casez (b)
      8'b0???????: push_cp({13'd0, b}, 1'b0);
      8'b110?????: begin
        cp_accum  = {16'd0, b[4:0]};
        seq_kind  = SEQ_TWO;
        conts_due = 2'd1;
      end
      8'b1110????: begin
        cp_accum  = {17'd0, b[3:0]};
        seq_kind  = SEQ_THREE;
        conts_due = 2'd2;
      end
      8'b11110???: begin
        cp_accum  = {18'd0, b[2:0]};
        seq_kind  = SEQ_FOUR;
        conts_due = 2'd3;
      end
      default: push_cp(REPL_CHAR, 1'b1);
    endcase
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    int          depth_before;
    logic [20:0] v;
    logic        bad;
    cp_word_t    w;
    depth_before = expected_cps.size();
    if (conts_due != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        v = {cp_accum[14:0], b[5:0]};
        cp_accum = v;
        conts_due = conts_due - 2'd1;
        if (conts_due == 2'd0) begin
          bad = (seq_kind == SEQ_TWO && v < MIN_2BYTE) ||
                (seq_kind == SEQ_THREE && v < MIN_3BYTE) ||
                (seq_kind == SEQ_FOUR && v < MIN_4BYTE) ||
                (v >= SURR_LO && v <= SURR_HI);
          push_cp(bad ? REPL_CHAR : v, bad);
          seq_kind = SEQ_NONE;
          cp_accum = '0;
        end
      end else begin
        // sequence cut short: replace it, then treat this byte as a fresh lead
        push_cp(REPL_CHAR, 1'b1);
        conts_due = 2'd0;
        seq_kind  = SEQ_NONE;
        cp_accum  = '0;
        open_sequence(b);
      end
    end else begin
      open_sequence(b);
    end
    if (expected_cps.size() > depth_before) begin
      w = expected_cps.pop_back();
      w.last = 1'b1;
      expected_cps.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    cp_word_t want;
    int       errs;
    errs = 0;
    if (rst) begin
      conts_due = 2'd0;
      seq_kind  = SEQ_NONE;
      cp_accum  = '0;
      expected_cps.delete();
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      if (byte_mon.valid && byte_mon.ready) decode_byte(byte_mon.byte_in);
      if (cp_mon.valid && cp_mon.ready) begin
        if (expected_cps.size() == 0) begin
          errs++;
          $display("%0t: unexpected word: expected none, actual cp=%06h repl=%0b last=%0b",
                   $time, cp_mon.code_point, cp_mon.replaced, cp_mon.last);
        end else begin
          want = expected_cps.pop_front();
          if (cp_mon.code_point !== want.code_point) begin
            errs++;
            $display("%0t: code_point mismatch: expected %06h, actual %06h",
                     $time, want.code_point, cp_mon.code_point);
          end
          if (cp_mon.replaced !== want.replaced) begin
            errs++;
            $display("%0t: replaced mismatch: expected %0b, actual %0b",
                     $time, want.replaced, cp_mon.replaced);
          end
          if (cp_mon.last !== want.last) begin
            errs++;
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, want.last, cp_mon.last);
          end
        end
      end
      fail_count  <= fail_count + errs;
      outstanding <= expected_cps.size();
    end
  end

endmodule

// ===== test/utf8_stream_decoder_tb.sv =====
// Top of the UTF-8 decoder testbench: clock, reset, byte stimulus, result pacing and verdict.
module utf8_stream_decoder_tb;

  typedef enum int {
    PACE_FREE,
    PACE_COIN,
    PACE_SPARSE,
    PACE_HOLD,
    PACE_MOSTLY
  } pace_t;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;
  int   burst_left;
  int   bytes_sent;

  u8d_byte_if byte_if();
  u8d_cp_if   cp_if();

  utf8_stream_decoder DUT (
    .clk        (clk),
    .rst        (rst),
    .byte_stream(byte_if),
    .cp_stream  (cp_if)
  );

  utf8_stream_decoder_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .byte_mon   (byte_if),
    .cp_mon     (cp_if),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20 * 200000);
    $display("FAIL utf8_stream_decoder");
    $finish;
  end

  // sender: bursts of words with idle gaps between them
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    byte_if.valid   <= 1'b1;
    byte_if.byte_in <= b;
    do @(posedge clk); while (!byte_if.ready);
    burst_left--;
    bytes_sent++;
  endtask

  // lead plus n_sent of n_conts continuations; n_sent < n_conts leaves it open
  task automatic send_sequence(input int n_conts, input int n_sent);
    logic [7:0] lead;
    logic [7:0] c1;
    int         flavor;
    flavor = $urandom_range(0, 7);
    c1 = {2'b10, 6'($urandom)};
    case (n_conts)
      1: lead = {3'b110, 5'($urandom)};
      2: lead = {4'b1110, 4'($urandom)};
      default: lead = {5'b11110, 3'($urandom)};
    endcase
    if (flavor == 0) begin
      // overlong: smallest lead payloads, with a small first continuation for 3 and 4 bytes
      case (n_conts)
        1: lead = {7'b1100000, 1'($urandom)};
        2: begin
          lead = 8'hE0;
          c1 = {3'b100, 5'($urandom)};
        end
        default: begin
          lead = 8'hF0;
          c1 = {4'b1000, 4'($urandom)};
        end
      endcase
    end else if (flavor == 1 && n_conts == 2) begin
      lead = 8'hED;
      c1 = {3'b101, 5'($urandom)};
    end
    send_byte(lead);
    if (n_sent >= 1) send_byte(c1);
    for (int i = 1; i < n_sent; i++) send_byte({2'b10, 6'($urandom)});
  endtask

  initial begin
    logic [7:0] directed[$];
    int         pick;
    int         conts;
    directed = {
      8'h00, 8'h7F, 8'h80, 8'hFF, 8'hF8,   // ASCII ends, stray continuation, bad leads
      8'hC2, 8'h80,                        // smallest 2-byte value
      8'hC0, 8'hAF,                        // overlong 2-byte
      8'hED, 8'hA0, 8'h80,                 // surrogate
      8'hF0, 8'h90, 8'h80, 8'h80,          // smallest 4-byte value
      8'hF7, 8'hBF, 8'hBF, 8'hBF,          // top of the 21-bit range, passed through
      8'hE4, 8'h41,                        // cut short by ASCII: two words
      8'hC3, 8'hE2, 8'h82, 8'hAC,          // cut short by a new lead: one word, then euro sign
      8'hF0, 8'hFF                         // cut short by a bad lead: two replacements
    };
    rst = 1'b1;
    byte_if.valid = 1'b0;
    byte_if.byte_in = 8'h00;
    burst_left = 0;
    bytes_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_byte(directed[i]);

    while (bytes_sent < 1130) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) send_byte({1'b0, 7'($urandom)});
      else if (pick < 42) send_sequence(1, 1);
      else if (pick < 62) send_sequence(2, 2);
      else if (pick < 78) send_sequence(3, 3);
      else if (pick < 88) begin
        conts = $urandom_range(1, 3);
        send_sequence(conts, $urandom_range(0, conts - 1));
      end else send_byte(8'($urandom));
    end
    byte_if.valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) $display("PASS utf8_stream_decoder");
    else $display("FAIL utf8_stream_decoder");
    $finish;
  end

  // receiver: phases of free flow, random stalls, sparse accepts and long holds
  initial begin
    pace_t mode;
    int    span;
    int    phase_no;
    int    tick;
    cp_if.ready = 1'b0;
    phase_no = 0;
    tick = 0;
    repeat (3) @(posedge clk);
    forever begin
      mode = pace_t'($urandom_range(0, 4));
      span = $urandom_range(10, 60);
      // third phase is always a long hold so the result queue fills and input stalls
      if (phase_no == 2) mode = PACE_HOLD;
      if (mode == PACE_HOLD) span = $urandom_range(60, 100);
      phase_no++;
      repeat (span) begin
        case (mode)
          PACE_FREE:   cp_if.ready <= 1'b1;
          PACE_COIN:   cp_if.ready <= 1'($urandom);
          PACE_SPARSE: cp_if.ready <= (tick % 4 == 0);
          PACE_HOLD:   cp_if.ready <= 1'b0;
          default:     cp_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
        tick++;
        @(posedge clk);
      end
    end
  end

endmodule
